// ===== hdl/rbc_pkg.sv =====
`timescale 1ns / 1ps

package rbc_pkg;

   // Field and register widths
   localparam int CFG_W     = 20;
   localparam int WIN_W     = 24;
   localparam int ID_W      = 32;
   localparam int LEN_W     = 16;
   localparam int KV_W      = 21;
   localparam int IDX_W     = 5;
   localparam int SLOT_W    = 6;
   localparam int TOT_W     = 22;
   localparam int CSR_IDX_W = 2;

   localparam logic [WIN_W-1:0] WIN_MAX = '1;

   // Result kinds
   localparam logic [1:0] KIND_ACK    = 2'd0;
   localparam logic [1:0] KIND_SLOT   = 2'd1;
   localparam logic [1:0] KIND_REJECT = 2'd2;

   // Request functions
   localparam logic FUNC_SUBMIT = 1'b0;
   localparam logic FUNC_TICK   = 1'b1;

   // Register map
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_BATCH_SIZE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_BATCH_TOKENS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_WINDOW      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ADAPTIVE_EN      = 2'd3;

   // Register reset values
   localparam logic [SLOT_W-1:0] RST_MAX_BATCH_SIZE   = 6'd8;
   localparam logic [CFG_W-1:0]  RST_MAX_BATCH_TOKENS = 20'd4096;
   localparam logic [CFG_W-1:0]  RST_BASE_WINDOW      = 20'd2000;
   localparam logic              RST_ADAPTIVE_EN      = 1'b1;

   typedef struct packed {
      logic             func;
      logic [LEN_W-1:0] prompt_len;
   } req_type;

   typedef struct packed {
      logic [1:0]       kind;
      logic [ID_W-1:0]  request_id;
      logic [ID_W-1:0]  batch_id;
      logic [IDX_W-1:0] slot_index;
      logic [KV_W-1:0]  kv_offset;
      logic [LEN_W-1:0] slot_tokens;
      logic             last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SLOT,
      ST_ADAPT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;
      logic check;
      logic start_batch;
      logic take_slot;
      logic stop_batch;
      logic adapt;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic reject;
      logic due;
      logic slot_ok;
   } status_type;

endpackage

// ===== hdl/request_batch_coalescer_unit.sv =====
`timescale 1ns / 1ps

// Channel   Ports                               Handshake
// request   start, busy, req_data               taken when start is high and busy is low
// result    rsp_valid, rsp_data                 one beat per cycle of rsp_valid, never held off
// control   csr_we, csr_index, csr_wdata        written at every clock edge with csr_we high
//
// A tick or a submit that dispatches nothing passes through ST_CHECK only; a reject stays in ST_IDLE.
// A dispatched batch then runs ST_SLOT and ST_ADAPT: the slot loop reads one queue
// entry per cycle through the registered read port of the queue memory.
// Reset is synchronous and active high; the queue needs no clearing pass.
// Results are never stalled: each beat shows on rsp_valid for exactly one cycle.

module request_batch_coalescer_unit
   import rbc_pkg::*;
#(
   parameter int QUEUE_DEPTH = 64,
   parameter int MAX_SLOTS   = 32,
   parameter int MIN_WINDOW  = 500
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_data,
   output logic                 rsp_valid,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   cmd_type    cmd;
   status_type status;

   rbc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   rbc_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .MAX_SLOTS   (MAX_SLOTS),
      .MIN_WINDOW  (MIN_WINDOW)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hdl/rbc_ctrl.sv =====
`timescale 1ns / 1ps

module rbc_ctrl
   import rbc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               // a rejected submit is answered at once and changes nothing
               if (!status.reject) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            if (status.due) begin
               cmd.start_batch = 1'b1;
               state_in        = ST_SLOT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SLOT: begin
            if (status.slot_ok) begin
               cmd.take_slot = 1'b1;
            end else begin
               cmd.stop_batch = 1'b1;
               state_in       = ST_ADAPT;
            end
         end
         ST_ADAPT: begin
            cmd.adapt = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== hdl/rbc_datapath.sv =====
`timescale 1ns / 1ps

module rbc_datapath
   import rbc_pkg::*;
#(
   parameter int QUEUE_DEPTH = 64,
   parameter int MAX_SLOTS   = 32,
   parameter int MIN_WINDOW  = 500
) (
   input  logic                 clock,
   input  logic                 reset,
   input  req_type              req_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   input  cmd_type              cmd,
   output status_type           status,
   output logic                 rsp_valid,
   output rsp_type              rsp_data
);

   localparam int AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int PW    = AW + 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int CMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
   localparam int ENT_W = ID_W + LEN_W;

   localparam logic [SLOT_W-1:0] MaxSlots = SLOT_W'(MAX_SLOTS);
   localparam logic [WIN_W-1:0]  MinWin   = WIN_W'(MIN_WINDOW);
   localparam logic [CNT_W-1:0]  QFull    = CNT_W'(QUEUE_DEPTH);
   localparam logic [PW-1:0]     QWrap    = PW'(QUEUE_DEPTH);
   localparam logic [AW-1:0]     QLast    = AW'(QUEUE_DEPTH - 1);

   // Configuration
   logic [SLOT_W-1:0] cfg_size_ff;
   logic [CFG_W-1:0]  cfg_tokens_ff;
   logic [CFG_W-1:0]  cfg_base_ff;
   logic              cfg_adapt_ff;

   // Queue storage and pointers
   logic [ENT_W-1:0] queue_mem [QUEUE_DEPTH];
   logic [ENT_W-1:0] rd_data_ff;
   logic [AW-1:0]    head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             mem_we;
   logic [AW-1:0]    tail;
   logic [PW-1:0]    tail_sum;
   logic [AW-1:0]    head_step;

   // Ids and window
   logic [ID_W-1:0]  next_req_ff, next_req_in;
   logic [ID_W-1:0]  next_batch_ff, next_batch_in;
   logic [WIN_W-1:0] win_ff, win_in;
   logic [WIN_W-1:0] elapsed_ff, elapsed_in;
   logic             open_ff, open_in;

   // Pending acknowledge
   logic             ack_pend_ff, ack_pend_in;
   logic [ID_W-1:0]  ack_id_ff, ack_id_in;
   logic [LEN_W-1:0] ack_len_ff, ack_len_in;

   // Batch under way
   logic [ID_W-1:0]   bid_ff, bid_in;
   logic [SLOT_W-1:0] n_ff, n_in;
   logic [TOT_W-1:0]  total_ff, total_in;
   rsp_type           held_ff, held_in;

   // Result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // Decode helpers
   logic [SLOT_W-1:0] limit;
   logic              full;
   logic              reject;
   logic              due;
   logic              slot_ok;
   logic [LEN_W-1:0]  rd_len;
   logic [ID_W-1:0]   rd_id;
   logic [TOT_W:0]    fit_sum;
   logic [9:0]        fill5, fill10, lim4, lim3;
   logic [WIN_W-1:0]  base4;
   logic [WIN_W:0]    grow_sum;

   // Slot limit clamped to 1..MAX_SLOTS
   always_comb begin
      if (cfg_size_ff == '0) begin
         limit = SLOT_W'(1);
      end else if (cfg_size_ff > MaxSlots) begin
         limit = MaxSlots;
      end else begin
         limit = cfg_size_ff;
      end
   end

   // Queue arithmetic
   assign full      = (count_ff == QFull);
   assign reject    = (req_data.func == FUNC_SUBMIT) && full;
   assign tail_sum  = PW'(head_ff) + PW'(count_ff);
   assign tail      = (tail_sum >= QWrap) ? AW'(tail_sum - QWrap) : AW'(tail_sum);
   assign head_step = (head_ff == QLast) ? '0 : head_ff + AW'(1);

   assign rd_len  = rd_data_ff[LEN_W-1:0];
   assign rd_id   = rd_data_ff[LEN_W +: ID_W];
   assign fit_sum = {1'b0, total_ff} + (TOT_W + 1)'(rd_len);

   // Batch due and slot admission
   assign due = open_ff && (count_ff != '0) &&
                ((elapsed_ff >= win_ff) || (CMP_W'(count_ff) >= CMP_W'(limit)));
   assign slot_ok = (count_ff != '0) && (n_ff < limit) &&
                    ((n_ff == '0) || (fit_sum <= (TOT_W + 1)'(cfg_tokens_ff)));

   assign status.reject  = reject;
   assign status.due     = due;
   assign status.slot_ok = slot_ok;

   // Fill ratio terms for window adaptation
   assign fill5    = 10'(n_ff) * 10'd5;
   assign fill10   = 10'(n_ff) * 10'd10;
   assign lim4     = 10'(limit) * 10'd4;
   assign lim3     = 10'(limit) * 10'd3;
   assign base4    = WIN_W'({cfg_base_ff, 2'b00});
   assign grow_sum = {1'b0, win_ff} + (WIN_W + 1)'(win_ff >> 2);

   // Next state of the datapath
   always_comb begin
      head_in       = head_ff;
      count_in      = count_ff;
      next_req_in   = next_req_ff;
      next_batch_in = next_batch_ff;
      win_in        = win_ff;
      elapsed_in    = elapsed_ff;
      open_in       = open_ff;
      ack_pend_in   = ack_pend_ff;
      ack_id_in     = ack_id_ff;
      ack_len_in    = ack_len_ff;
      bid_in        = bid_ff;
      n_in          = n_ff;
      total_in      = total_ff;
      held_in       = held_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      mem_we        = 1'b0;

      // item intake
      if (cmd.accept) begin
         ack_pend_in = 1'b0;
         if (reject) begin
            rsp_valid_in = 1'b1;
            rsp_in       = '0;
            rsp_in.kind  = KIND_REJECT;
            rsp_in.last  = 1'b1;
         end else if (req_data.func == FUNC_SUBMIT) begin
            mem_we      = 1'b1;
            count_in    = count_ff + CNT_W'(1);
            next_req_in = next_req_ff + ID_W'(1);
            ack_pend_in = 1'b1;
            ack_id_in   = next_req_ff;
            ack_len_in  = req_data.prompt_len;
            if (!open_ff) begin
               open_in    = 1'b1;
               elapsed_in = '0;
            end
         end else if (open_ff && (elapsed_ff != WIN_MAX)) begin
            elapsed_in = elapsed_ff + WIN_W'(1);
         end
      end

      // acknowledge beat, last unless a batch follows
      if (cmd.check && ack_pend_ff) begin
         rsp_valid_in       = 1'b1;
         rsp_in             = '0;
         rsp_in.kind        = KIND_ACK;
         rsp_in.request_id  = ack_id_ff;
         rsp_in.slot_tokens = ack_len_ff;
         rsp_in.last        = !due;
      end

      if (cmd.start_batch) begin
         bid_in        = next_batch_ff;
         next_batch_in = next_batch_ff + ID_W'(1);
         n_in          = '0;
         total_in      = '0;
      end

      // each slot is held in held_ff until it is known whether another follows
      if (cmd.take_slot) begin
         if (n_ff != '0) begin
            rsp_valid_in = 1'b1;
            rsp_in       = held_ff;
            rsp_in.last  = 1'b0;
         end
         held_in.kind        = KIND_SLOT;
         held_in.request_id  = rd_id;
         held_in.batch_id    = bid_ff;
         held_in.slot_index  = n_ff[IDX_W-1:0];
         held_in.kv_offset   = total_ff[KV_W-1:0];
         held_in.slot_tokens = rd_len;
         held_in.last        = 1'b0;
         head_in  = head_step;
         count_in = count_ff - CNT_W'(1);
         n_in     = n_ff + SLOT_W'(1);
         total_in = total_ff + TOT_W'(rd_len);
      end

      if (cmd.stop_batch) begin
         rsp_valid_in = 1'b1;
         rsp_in       = held_ff;
         rsp_in.last  = 1'b1;
      end

      // window adaptation and reopen
      if (cmd.adapt) begin
         if (cfg_adapt_ff) begin
            if ((fill5 > lim4) && (win_ff < base4)) begin
               win_in = grow_sum[WIN_W] ? WIN_MAX : grow_sum[WIN_W-1:0];
            end else if ((fill10 < lim3) && (win_ff > MinWin)) begin
               win_in = win_ff - (win_ff >> 2);
            end
         end
         elapsed_in = '0;
         open_in    = (count_ff != '0);
      end

      // base window write reloads the running window
      if (csr_we && (csr_index == CSR_BASE_WINDOW)) begin
         win_in = WIN_W'(csr_wdata);
      end
   end

   // Queue memory: one write port, registered read at the next head
   always_ff @(posedge clock) begin
      if (mem_we) begin
         queue_mem[tail] <= {next_req_ff, req_data.prompt_len};
      end
      rd_data_ff <= queue_mem[head_in];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_size_ff   <= RST_MAX_BATCH_SIZE;
         cfg_tokens_ff <= RST_MAX_BATCH_TOKENS;
         cfg_base_ff   <= RST_BASE_WINDOW;
         cfg_adapt_ff  <= RST_ADAPTIVE_EN;
         head_ff       <= '0;
         count_ff      <= '0;
         next_req_ff   <= '0;
         next_batch_ff <= '0;
         win_ff        <= WIN_W'(RST_BASE_WINDOW);
         elapsed_ff    <= '0;
         open_ff       <= 1'b0;
         ack_pend_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_MAX_BATCH_SIZE:   cfg_size_ff   <= csr_wdata[SLOT_W-1:0];
               CSR_MAX_BATCH_TOKENS: cfg_tokens_ff <= csr_wdata;
               CSR_BASE_WINDOW:      cfg_base_ff   <= csr_wdata;
               CSR_ADAPTIVE_EN:      cfg_adapt_ff  <= csr_wdata[0];
               default: ;
            endcase
         end
         head_ff       <= head_in;
         count_ff      <= count_in;
         next_req_ff   <= next_req_in;
         next_batch_ff <= next_batch_in;
         win_ff        <= win_in;
         elapsed_ff    <= elapsed_in;
         open_ff       <= open_in;
         ack_pend_ff   <= ack_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      ack_id_ff  <= ack_id_in;
      ack_len_ff <= ack_len_in;
      bid_ff     <= bid_in;
      n_ff       <= n_in;
      total_ff   <= total_in;
      held_ff    <= held_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // a closed window means nothing is pending
   a_closed_empty: assert property (@(posedge clock) disable iff (reset)
      !open_ff |-> (count_ff == '0))
      else $error("window closed with requests pending");

   // slot beats come only out of the slot loop
   a_slot_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.kind == KIND_SLOT) && !$past(reset)) |->
         ($past(cmd.take_slot) || $past(cmd.stop_batch)))
      else $error("slot beat outside a dispatch");

   // every slot after the first stays within the token budget
   a_slot_budget: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.kind == KIND_SLOT) && (rsp_ff.slot_index != '0)) |->
         (({1'b0, rsp_ff.kv_offset} + (KV_W + 1)'(rsp_ff.slot_tokens)) <=
          (KV_W + 1)'(cfg_tokens_ff)))
      else $error("slot exceeds token budget");

   // after a batch the window restarts and reflects what is left
   a_reopen: assert property (@(posedge clock) disable iff (reset)
      ($past(cmd.adapt) && !$past(reset)) |->
         ((elapsed_ff == '0) && (open_ff == (count_ff != '0))))
      else $error("window not restarted after batch");
`endif

endmodule
